// ----- design/tpcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tpcl_pkg
// Shared constants of the threshold promote cache list: default sizes,
// port widths, configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package tpcl_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int LOOKUP_KEY_BITS = 64;
  localparam int POSITION_BITS   = 4;
  localparam int HIT_COUNT_BITS  = 16;
  localparam int THRESHOLD_BITS  = 16;
  localparam int CAPACITY_BITS   = 5;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PROMOTE_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY          = 8'd1;

  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd2;
  localparam logic [CAPACITY_BITS-1:0]  CAPACITY_RESET  = 5'd16;

endpackage

// ----- design/threshold_promote_cache_list_core.sv -----
// ----------------------------------------------------------------------------
// threshold_promote_cache_list_core
// Ordered key list with saturating hit counts; hot entries move to the front.
// ----------------------------------------------------------------------------
// One request at a time goes through a single entry memory under a small
// sequencer. The search reads the entries one by one from the front; a hit
// behind the front whose count passes the threshold is then moved there by
// shifting the entries before it back one place, and a plain hit writes its
// count back in the compare cycle itself. A miss searches the whole list,
// checks the fill, makes one more read when the list is full, and shifts
// the entries back one place to insert the key at the front. The done
// state then hands the result to the output register, and the block takes
// the next request in the cycle after that. A result the receiver has not
// taken yet holds the block in the done state. The memory's single read
// port and single write port make the search and the shift go one entry at
// a time. The memory needs no clearing after reset.
module threshold_promote_cache_list_core #(
  parameter int MAX_ENTRIES = tpcl_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = tpcl_pkg::DEF_KEY_BITS,
  parameter int COUNT_BITS  = tpcl_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tpcl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tpcl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tpcl_pkg::LOOKUP_KEY_BITS-1:0]  lookup_key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  hit,
  output logic [tpcl_pkg::POSITION_BITS-1:0]    hit_position,
  output logic [tpcl_pkg::HIT_COUNT_BITS-1:0]   hit_count,
  output logic                                  promoted,
  output logic                                  evicted,
  output logic [tpcl_pkg::LOOKUP_KEY_BITS-1:0]  evicted_key
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = tpcl_pkg::POSITION_BITS;
  localparam int HW = tpcl_pkg::HIT_COUNT_BITS;
  localparam logic [8:0]            MAX9      = 9'(MAX_ENTRIES);
  localparam logic [NW-1:0]         MAX_N     = NW'(MAX_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_MISS = 3'd5;
  localparam logic [2:0] S_EVRD = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                          state;
  logic [tpcl_pkg::THRESHOLD_BITS-1:0] threshold;
  logic [tpcl_pkg::CAPACITY_BITS-1:0]  capacity;
  logic [NW-1:0]                       occ;
  logic [KEY_BITS-1:0]                 key;
  logic [NW-1:0]                       idx;
  logic [AW-1:0]                       sh;
  logic [AW-1:0]                       pos;
  logic [COUNT_BITS-1:0]               cnt;
  logic                                hit_f;
  logic                                prom_f;
  logic                                ev_f;
  logic [KEY_BITS-1:0]                 ev_key;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_count;
  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_count;

  logic [8:0]            cap9;
  logic [NW-1:0]         cap_eff;
  logic [AW-1:0]         cap_last;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  over_thr;
  logic                  key_eq;

  tpcl_store #(
    .DEPTH      (MAX_ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_count (wr_count),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_count (rd_count)
  );

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    cap9 = 9'(capacity);
    if (cap9 == 9'd0) begin
      cap9 = 9'd1;
    end
    if (cap9 > MAX9) begin
      cap9 = MAX9;
    end
    cap_eff  = cap9[NW-1:0];
    cap_last = AW'(cap_eff - NW'(1));
  end

  assign key_eq   = (rd_key == key);
  assign cnt_inc  = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_ONE;
  assign over_thr = (32'(cnt_inc) > 32'(threshold));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_SHRD:  rd_addr = sh - AW'(1);
      S_MISS:  rd_addr = cap_last;
      default: rd_addr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = sh;
    wr_key   = key;
    wr_count = cnt;
    case (state)
      S_CMP: begin
        // plain hit: count update in place
        wr_en    = key_eq && !(over_thr && idx != '0);
        wr_addr  = idx[AW-1:0];
        wr_count = cnt_inc;
      end
      S_SHRD: begin
        wr_en   = (sh == '0);
        wr_addr = '0;
      end
      S_SHWR: begin
        wr_en    = 1'b1;
        wr_key   = rd_key;
        wr_count = rd_count;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tpcl_pkg::THRESHOLD_RESET;
      capacity  <= tpcl_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tpcl_pkg::REG_PROMOTE_THRESHOLD) begin
        threshold <= cfg_data[tpcl_pkg::THRESHOLD_BITS-1:0];
      end else if (cfg_index == tpcl_pkg::REG_CAPACITY) begin
        capacity <= cfg_data[tpcl_pkg::CAPACITY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key    <= lookup_key[KEY_BITS-1:0];
            idx    <= '0;
            hit_f  <= 1'b0;
            prom_f <= 1'b0;
            ev_f   <= 1'b0;
            ev_key <= '0;
            pos    <= '0;
            cnt    <= COUNT_ONE;
            state  <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (idx >= occ) begin
            state <= S_MISS;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_eq) begin
            hit_f <= 1'b1;
            pos   <= idx[AW-1:0];
            cnt   <= cnt_inc;
            sh    <= idx[AW-1:0];
            if (over_thr && idx != '0) begin
              prom_f <= 1'b1;
              state  <= S_SHRD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            idx   <= idx + NW'(1);
            state <= S_SRCH;
          end
        end
        S_SHRD: begin
          if (sh == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          sh    <= sh - AW'(1);
          state <= S_SHRD;
        end
        S_MISS: begin
          // full list: keep the first capacity-1 entries; the one at position capacity-1 is reported
          if (occ >= cap_eff) begin
            ev_f  <= 1'b1;
            sh    <= cap_last;
            occ   <= cap_eff;
            state <= S_EVRD;
          end else begin
            sh    <= occ[AW-1:0];
            occ   <= occ + NW'(1);
            state <= S_SHRD;
          end
        end
        S_EVRD: begin
          ev_key <= rd_key;
          state  <= S_SHRD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            hit          <= hit_f;
            hit_position <= PW'(pos);
            hit_count    <= HW'(cnt);
            promoted     <= prom_f;
            evicted      <= ev_f;
            evicted_key  <= 64'(ev_key);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= MAX_N)
    else $error("occupancy above list size");

  a_occ_after_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != '0)
    else $error("empty list after a completed request");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted && evicted_key == '0)
    else $error("eviction reported on a hit");

  a_promote_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && promoted |-> hit && hit_position != '0)
    else $error("promotion without a hit behind the front");

  a_miss_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_position == '0 && !promoted)
    else $error("miss result fields wrong");

endmodule

// ----- design/tpcl_store.sv -----
// ----------------------------------------------------------------------------
// tpcl_store
// Entry memory of the cache list: key and hit count per list position,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpcl_store #(
  parameter int DEPTH      = tpcl_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS   = tpcl_pkg::DEF_KEY_BITS,
  parameter int COUNT_BITS = tpcl_pkg::DEF_COUNT_BITS,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [COUNT_BITS-1:0] wr_count,
  input  logic [AW-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [COUNT_BITS-1:0] rd_count
);

  logic [KEY_BITS-1:0]   keys   [DEPTH];
  logic [COUNT_BITS-1:0] counts [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr]   <= wr_key;
      counts[wr_addr] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= keys[rd_addr];
    rd_count <= counts[rd_addr];
  end

endmodule
